/* design/bmpe_pkg.sv */
package bmpe_pkg;

  localparam int CFG_W = 13;

  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  localparam logic [5:0] OFS_FILE_SIZE = 6'd2;
  localparam logic [5:0] OFS_DATA_OFS  = 6'd10;
  localparam logic [5:0] OFS_INFO_SIZE = 6'd14;
  localparam logic [5:0] OFS_WIDTH     = 6'd18;
  localparam logic [5:0] OFS_HEIGHT    = 6'd22;
  localparam logic [5:0] OFS_PLANES    = 6'd26;
  localparam logic [5:0] OFS_BPP       = 6'd28;
  localparam logic [5:0] OFS_IMG_SIZE  = 6'd34;
  localparam logic [5:0] OFS_XPPM      = 6'd38;
  localparam logic [5:0] OFS_YPPM      = 6'd42;
  localparam logic [5:0] OFS_BLUE      = 6'd54;
  localparam logic [5:0] OFS_GREEN     = 6'd55;
  localparam logic [5:0] OFS_RED       = 6'd56;

  localparam logic [31:0] HDR_BYTES  = 32'd54;
  localparam logic [31:0] INFO_BYTES = 32'd40;
  localparam logic [31:0] PPM        = 32'd2835;
  localparam logic [7:0]  MAGIC_LO   = 8'h42;
  localparam logic [7:0]  MAGIC_HI   = 8'h4D;
  localparam logic [7:0]  PLANES     = 8'd1;
  localparam logic [7:0]  BPP        = 8'd24;
  localparam logic [7:0]  PAD_BYTE   = 8'h2E;

  typedef struct packed {
    logic       hdr;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [1:0] pad;
    logic       img_end;
  } queue_entry_t;

  // Exact floor(c * a / 255) for any 16-bit product of two bytes.
  function automatic logic [7:0] blend(input logic [7:0] c, input logic [7:0] a);
    logic [15:0] x;
    logic [16:0] s;
    x = 16'(c) * 16'(a);
    s = 17'(x) + 17'(x[15:8]) + 17'd1;
    return s[15:8];
  endfunction

  function automatic logic [7:0] le_byte(input logic [31:0] word, input logic [1:0] sel);
    return word[8*sel +: 8];
  endfunction

  function automatic logic [7:0] hdr_byte(input logic [5:0] idx, input logic [31:0] fsz,
                                          input logic [31:0] isz, input logic [31:0] w,
                                          input logic [31:0] h);
    logic [7:0] b;
    b = 8'h00;
    case (idx) inside
      6'd0:      b = MAGIC_LO;
      6'd1:      b = MAGIC_HI;
      [6'd2:6'd5]:   b = le_byte(fsz, 2'(idx - OFS_FILE_SIZE));
      [6'd10:6'd13]: b = le_byte(HDR_BYTES, 2'(idx - OFS_DATA_OFS));
      [6'd14:6'd17]: b = le_byte(INFO_BYTES, 2'(idx - OFS_INFO_SIZE));
      [6'd18:6'd21]: b = le_byte(w, 2'(idx - OFS_WIDTH));
      [6'd22:6'd25]: b = le_byte(h, 2'(idx - OFS_HEIGHT));
      6'd26:     b = PLANES;
      6'd28:     b = BPP;
      [6'd34:6'd37]: b = le_byte(isz, 2'(idx - OFS_IMG_SIZE));
      [6'd38:6'd41]: b = le_byte(PPM, 2'(idx - OFS_XPPM));
      [6'd42:6'd45]: b = le_byte(PPM, 2'(idx - OFS_YPPM));
      default:   b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

/* design/bmpe_if.sv */
interface bmpe_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;

  modport source (output valid, output red, output green, output blue, output alpha,
                  input ready);
  modport sink (input valid, input red, input green, input blue, input alpha,
                output ready);
endinterface

interface bmpe_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       image_done;

  modport source (output valid, output out_byte, output run_last, output image_done,
                  input ready);
  modport sink (input valid, input out_byte, input run_last, input image_done,
                output ready);
endinterface

/* design/bmpe_front.sv */
module bmpe_front import bmpe_pkg::*; #(
  parameter int DW = 13
) (
  input  logic          clk,
  input  logic          rst,
  bmpe_pixel_if.sink    pix,
  input  logic [DW-1:0] dim_w,
  input  logic [DW-1:0] dim_h,
  input  logic          q_full,
  output logic          push,
  output queue_entry_t  entry
);

  logic [DW-1:0] column_count;
  logic [DW-1:0] row_count;
  logic          row_end;
  logic          img_end;

  assign pix.ready = !q_full;
  assign push      = pix.valid && !q_full;

  assign row_end = ({1'b0, column_count} + (DW+1)'(1)) >= {1'b0, dim_w};
  assign img_end = row_end && (({1'b0, row_count} + (DW+1)'(1)) >= {1'b0, dim_h});

  always_comb begin
    entry.hdr     = (column_count == '0) && (row_count == '0);
    entry.blue    = blend(pix.blue, pix.alpha);
    entry.green   = blend(pix.green, pix.alpha);
    entry.red     = blend(pix.red, pix.alpha);
    entry.pad     = row_end ? 2'(dim_w) : 2'd0;
    entry.img_end = img_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (push) begin
      if (row_end) begin
        column_count <= '0;
        row_count    <= img_end ? '0 : row_count + DW'(1);
      end else begin
        column_count <= column_count + DW'(1);
      end
    end
  end

endmodule

/* design/bmpe_queue.sv */
module bmpe_queue import bmpe_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  queue_entry_t push_data,
  input  logic         pop,
  output logic         full,
  output logic         head_valid,
  output queue_entry_t head
);

  queue_entry_t slots [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* design/bmpe_back.sv */
module bmpe_back import bmpe_pkg::*; #(
  parameter int DW = 13
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [DW-1:0] dim_w,
  input  logic [DW-1:0] dim_h,
  input  logic          head_valid,
  input  queue_entry_t  head,
  output logic          pop,
  bmpe_byte_if.source   out
);

  logic [DW+1:0] stride;
  logic [31:0]   img_size;
  logic [31:0]   total_len;
  logic          started;
  logic [5:0]    idx;
  logic [5:0]    cur;
  logic [5:0]    last_idx;
  logic          is_last;
  logic          emit;
  logic [7:0]    byte_next;

  assign stride = (DW+2)'(dim_w) * (DW+2)'(3) + (DW+2)'(2'(dim_w));

  always_ff @(posedge clk) begin
    img_size  <= 32'((2*DW+2)'(dim_h) * (2*DW+2)'(stride));
    total_len <= img_size + HDR_BYTES;
  end

  assign cur      = started ? idx : (head.hdr ? 6'd0 : OFS_BLUE);
  assign last_idx = OFS_RED + 6'(head.pad);
  assign is_last  = (cur == last_idx);
  assign emit     = head_valid && (!out.valid || out.ready);
  assign pop      = emit && is_last;

  always_comb begin
    if (cur < OFS_BLUE) begin
      byte_next = hdr_byte(cur, total_len, img_size, 32'(dim_w), 32'(dim_h));
    end else if (cur == OFS_BLUE) begin
      byte_next = head.blue;
    end else if (cur == OFS_GREEN) begin
      byte_next = head.green;
    end else if (cur == OFS_RED) begin
      byte_next = head.red;
    end else begin
      byte_next = PAD_BYTE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started   <= 1'b0;
      idx       <= 6'd0;
      out.valid <= 1'b0;
    end else begin
      if (emit) begin
        out.valid <= 1'b1;
        started   <= !is_last;
        idx       <= cur + 6'd1;
      end else if (out.ready) begin
        out.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out.out_byte   <= byte_next;
      out.run_last   <= is_last;
      out.image_done <= is_last && head.img_end;
    end
  end

endmodule

/* design/bmp24_stream_encoder_unit.sv */
// The first byte of a pixel passes through the queue and then the output register.
// Throughput: one byte per cycle from the output register while byte_out is ready,
// so a pixel gives 3 to 6 bytes, plus 54 header bytes on the first pixel of an image.
// A two-entry queue lets pixels be accepted while earlier ones are still being sent.
// Synchronous reset sets both dimensions to 1, clears the counters, and empties
// the queue and the output register.
module bmp24_stream_encoder_unit import bmpe_pkg::*; #(
  parameter int MAX_DIM = 4096
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  bmpe_pixel_if.sink       pixel_in,
  bmpe_byte_if.source      byte_out
);

  localparam int DW = $clog2(MAX_DIM + 1);

  logic [CFG_W-1:0] image_width;
  logic [CFG_W-1:0] image_height;
  logic [DW-1:0]    dim_w;
  logic [DW-1:0]    dim_h;
  logic             push;
  logic             pop;
  logic             q_full;
  logic             head_valid;
  queue_entry_t     entry;
  queue_entry_t     head;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= CFG_W'(1);
      image_height <= CFG_W'(1);
    end else if (cfg_we) begin
      if (cfg_index == REG_IMAGE_WIDTH) begin
        image_width <= cfg_data;
      end else begin
        image_height <= cfg_data;
      end
    end
  end

  always_comb begin
    if (image_width == '0) begin
      dim_w = DW'(1);
    end else if (32'(image_width) > 32'(MAX_DIM)) begin
      dim_w = DW'(MAX_DIM);
    end else begin
      dim_w = DW'(image_width);
    end
    if (image_height == '0) begin
      dim_h = DW'(1);
    end else if (32'(image_height) > 32'(MAX_DIM)) begin
      dim_h = DW'(MAX_DIM);
    end else begin
      dim_h = DW'(image_height);
    end
  end

  bmpe_front #(.DW(DW)) u_front (
    .clk    (clk),
    .rst    (rst),
    .pix    (pixel_in),
    .dim_w  (dim_w),
    .dim_h  (dim_h),
    .q_full (q_full),
    .push   (push),
    .entry  (entry)
  );

  bmpe_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (entry),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head)
  );

  bmpe_back #(.DW(DW)) u_back (
    .clk        (clk),
    .rst        (rst),
    .dim_w      (dim_w),
    .dim_h      (dim_h),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out        (byte_out)
  );

endmodule
